// ===== rtl/rpn_pkg.sv =====
// ============================================================================
// RPN stack calculator package
// Shared opcodes, result codes, payload structs and controller/datapath links.
// ============================================================================
package rpn_pkg;

    localparam int unsigned DefaultStackDepth = 16;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MOD   = 4'd5,
        OP_POW   = 4'd6,
        OP_POP   = 4'd7,
        OP_DEPTH = 4'd8
    } opcode_t;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_DEPTH = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_DIVZERO   = 2'd3;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [31:0] result_value;
        logic [1:0]         error_code;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_ops;   // capture next and top from the read ports
        logic start;      // begin the iterative operation
        logic step;       // one iteration step
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;       // iteration finished, result valid
    } dp_stat_t;

endpackage

// ===== rtl/rpn_ram.sv =====
// ============================================================================
// RPN generic RAM
// One write port and two read ports with registered read data.
// ============================================================================
module rpn_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr_a,
    output logic [Width-1:0]         rdata_a,
    input  logic [$clog2(Depth)-1:0] raddr_b,
    output logic [Width-1:0]         rdata_b
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ===== rtl/rpn_datapath.sv =====
// ============================================================================
// RPN arithmetic datapath
// Add, subtract, combinational multiply, bit-serial divide and iterative power.
// ============================================================================
module rpn_datapath (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [3:0]     opcode,
    input  logic [31:0]    next_in,
    input  logic [31:0]    top_in,
    input  rpn_pkg::dp_cmd_t  cmd,
    output rpn_pkg::dp_stat_t stat,
    output logic [31:0]    result,
    output logic           div_zero
);
    import rpn_pkg::*;

    logic [31:0] a_reg, b_reg, a_next, b_next;
    logic [31:0] quo_reg, quo_next, rem_reg, rem_next, acc_reg, acc_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [31:0] ua, ub, mag_q, mag_r;

    assign ua = a_reg[31] ? 32'd0 - a_reg : a_reg;
    assign ub = b_reg[31] ? 32'd0 - b_reg : b_reg;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, ub};
    assign div_zero = (b_reg == 32'd0);
    assign mag_q = (a_reg[31] != b_reg[31]) ? 32'd0 - quo_reg : quo_reg;
    assign mag_r = a_reg[31] ? 32'd0 - rem_reg : rem_reg;

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cmd.load_ops) begin
            a_next = next_in;
            b_next = top_in;
        end else if (cmd.start) begin
            // Only divide, modulo and power iterate; the rest finish at once.
            busy_next = (opcode == OP_DIV) || (opcode == OP_MOD) || (opcode == OP_POW);
            cnt_next  = 6'd32;
            acc_next  = 32'd1;
            quo_next  = ua;      // dividend shifts out of the quotient register
            rem_next  = 32'd0;
        end else if (cmd.step && busy_reg) begin
            if (opcode == OP_POW) begin
                if (b_reg[31]) begin
                    // Negative exponent: only a base of one or minus one survives.
                    busy_next = 1'b0;
                    priority if (a_reg == 32'd1) begin
                        acc_next = 32'd1;
                    end else if (a_reg == 32'hFFFF_FFFF) begin
                        acc_next = b_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                    end else begin
                        acc_next = 32'd0;
                    end
                end else if (b_reg == 32'd0) begin
                    busy_next = 1'b0;
                end else begin
                    if (b_reg[0]) begin
                        acc_next = acc_reg * a_reg;
                    end
                    a_next = a_reg * a_reg;
                    b_next = {1'b0, b_reg[31:1]};
                end
            end else begin
                if (!trial[32]) begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    assign stat.done = !busy_reg;

    always_comb begin
        unique case (opcode)
            OP_ADD:  result = a_reg + b_reg;
            OP_SUB:  result = a_reg - b_reg;
            OP_MUL:  result = a_reg * b_reg;
            OP_DIV:  result = div_zero ? a_reg : mag_q;
            OP_MOD:  result = div_zero ? a_reg : mag_r;
            default: result = acc_reg;
        endcase
    end
endmodule

// ===== rtl/rpn_ctrl.sv =====
// ============================================================================
// RPN controller
// Sequences each token: stack reads, arithmetic, write-back and result.
// ============================================================================
module rpn_ctrl #(
    parameter int unsigned StackDepth = rpn_pkg::DefaultStackDepth
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rpn_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rpn_pkg::out_item_t            m_data,
    output logic [3:0]                    opcode,
    output rpn_pkg::dp_cmd_t              cmd,
    input  rpn_pkg::dp_stat_t             stat,
    input  logic [31:0]                   dp_result,
    input  logic                          dp_div_zero,
    output logic                          ram_we,
    output logic [$clog2(StackDepth)-1:0] ram_waddr,
    output logic [31:0]                   ram_wdata,
    output logic [$clog2(StackDepth)-1:0] ram_raddr_a,
    output logic [$clog2(StackDepth)-1:0] ram_raddr_b,
    input  logic [31:0]                   ram_rdata_a
);
    import rpn_pkg::*;

    localparam int unsigned AddrW = $clog2(StackDepth);
    localparam int unsigned CntW  = $clog2(StackDepth + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_START = 6'b001000,
        ST_RUN   = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [3:0]    op_reg, op_next;
    logic [31:0]   val_reg, val_next;
    logic          pop_reg, pop_next;   // pop-output waiting for read data
    out_item_t     out_reg, out_next;
    logic          ovalid_reg, ovalid_next;
    logic          is_bin;

    assign opcode  = op_reg;
    assign s_ready = (state_reg == ST_IDLE) && (!ovalid_reg || m_ready);
    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;
    assign is_bin  = (s_data.opcode >= OP_ADD) && (s_data.opcode <= OP_POW);

    assign ram_raddr_a = AddrW'(count_reg - CntW'(1));
    assign ram_raddr_b = AddrW'(count_reg - CntW'(2));

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        pop_next    = 1'b0;
        out_next    = out_reg;
        ovalid_next = ovalid_reg && !m_ready;
        cmd         = '0;
        ram_we      = 1'b0;
        ram_waddr   = AddrW'(count_reg);
        ram_wdata   = val_reg;
        if (pop_reg) begin
            out_next    = '{KIND_VALUE, ram_rdata_a, ERR_NONE};
            ovalid_next = 1'b1;
            count_next  = count_reg - CntW'(1);
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next  = s_data.opcode;
                    val_next = s_data.operand_value;
                    priority if (s_data.opcode == OP_PUSH) begin
                        if (count_reg >= CntW'(StackDepth)) begin
                            out_next    = '{KIND_ERROR, 32'd0, ERR_OVERFLOW};
                            ovalid_next = 1'b1;
                        end else begin
                            ram_we     = 1'b1;
                            ram_wdata  = s_data.operand_value;
                            count_next = count_reg + CntW'(1);
                        end
                    end else if (s_data.opcode == OP_POP) begin
                        if (count_reg == '0) begin
                            out_next    = '{KIND_ERROR, 32'd0, ERR_UNDERFLOW};
                            ovalid_next = 1'b1;
                        end else begin
                            pop_next   = 1'b1;
                            state_next = ST_READ;
                        end
                    end else if (s_data.opcode == OP_DEPTH) begin
                        out_next    = '{KIND_DEPTH, 32'(count_reg), ERR_NONE};
                        ovalid_next = 1'b1;
                    end else if (is_bin) begin
                        if (count_reg < CntW'(2)) begin
                            out_next    = '{KIND_ERROR, 32'd0, ERR_UNDERFLOW};
                            ovalid_next = 1'b1;
                        end else begin
                            state_next = ST_READ;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                // Pop-output finishes here; binary ops wait for read data.
                if (op_reg == OP_POP) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_ops = 1'b1;
                state_next   = ST_START;
            end
            ST_START: begin
                cmd.start  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (stat.done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                ram_we     = 1'b1;
                ram_waddr  = AddrW'(count_reg - CntW'(2));
                ram_wdata  = dp_result;
                count_next = count_reg - CntW'(1);
                if ((op_reg == OP_DIV || op_reg == OP_MOD) && dp_div_zero) begin
                    out_next    = '{KIND_ERROR, 32'd0, ERR_DIVZERO};
                    ovalid_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            pop_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            pop_reg    <= pop_next;
        end
        op_reg  <= op_next;
        val_reg <= val_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(StackDepth))
        else $error("stack count beyond depth");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_write_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |=> (state_reg == ST_IDLE))
        else $error("write-back did not return to idle");
`endif
endmodule

// ===== rtl/rpn_integer_stack_alu.sv =====
// ============================================================================
// RPN integer stack ALU
// Reverse-Polish stack calculator: controller, datapath and stack RAM.
// ============================================================================
// Push, depth and error tokens are handled in the idle state; pop-output also
// passes through read. Add, subtract and multiply go through read, load,
// start, run and write; in run, divide and modulo iterate on the restoring
// divider, one bit per cycle; power squares and multiplies over exponent bits.
// One token is in work at a time; a result is held until transferred.
// aresetn is synchronous, active low, and empties the stack.
module rpn_integer_stack_alu #(
    parameter int unsigned STACK_DEPTH = rpn_pkg::DefaultStackDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpn_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rpn_pkg::out_item_t m_data
);
    import rpn_pkg::*;

    localparam int unsigned AddrW = $clog2(STACK_DEPTH);

    // Controller and datapath exchange commands, status, opcode, result and divide-by-zero flag.
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [3:0]  opcode;
    logic [31:0] dp_result;
    logic        dp_div_zero;

    // The stack lives in a two-read-port RAM: top on port a, next on port b.
    logic             ram_we;
    logic [AddrW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [31:0]      ram_wdata, ram_rdata_a, ram_rdata_b;

    rpn_ram #(.Width(32), .Depth(STACK_DEPTH)) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    rpn_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .opcode   (opcode),
        .next_in  (ram_rdata_b),
        .top_in   (ram_rdata_a),
        .cmd      (cmd),
        .stat     (stat),
        .result   (dp_result),
        .div_zero (dp_div_zero)
    );

    rpn_ctrl #(.StackDepth(STACK_DEPTH)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .opcode      (opcode),
        .cmd         (cmd),
        .stat        (stat),
        .dp_result   (dp_result),
        .dp_div_zero (dp_div_zero),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a)
    );
endmodule
